/* src/lrc_pkg.sv */
// Shared types and constants for the linear RGB to CIE L*a*b* converter.
// Used by linear_rgb_to_cielab and its port checker; depends on nothing.
package lrc_pkg;

  // Ratio Y/Yn and friends are Q7.24, saturated to 64.0.
  localparam int TW = 31;
  localparam logic [TW-1:0] T_MAX    = 31'h4000_0000;
  localparam logic [TW-1:0] T_THRESH = 31'd148579;

  // Cube root: the operand is t << 24, the root has at most 19 bits.
  localparam int NW = TW + 24;
  localparam int RW = 19;
  localparam int CW = 60;

  // Result word layout.
  localparam int LW    = 14;
  localparam int ABW   = 15;
  localparam int OUT_W = 48;

  // RGB to XYZ matrix, Q0.20.
  localparam logic [19:0] COEF [0:2][0:2] = '{
    '{20'd432488, 20'd374950, 20'd189187},
    '{20'd223002, 20'd749900, 20'd75675},
    '{20'd20273,  20'd124983, 20'd996385}
  };

  // Linear segment of f and the low-light branch of L*.
  localparam logic [18:0] LIN_SLOPE  = 19'd510329;
  localparam logic [14:0] LIN_OFFSET = 15'd9039;
  localparam logic [16:0] L_SLOPE    = 17'd90330;

  // Output scaling, hundredths.
  localparam logic [13:0] L_SCALE = 14'd11600;
  localparam logic [17:0] L_OFS   = 18'd1600;
  localparam logic [13:0] L_MAX   = 14'd10000;
  localparam logic signed [16:0] A_SCALE = 17'sd50000;
  localparam logic signed [16:0] B_SCALE = 17'sd20000;
  localparam int AB_POS_MAX = 12799;
  localparam int AB_NEG_MAX = 12800;

  // Reference white after reset: D65 with Y normalized to one, Q2.14.
  localparam logic [15:0] WHITE_X_RST = 16'd15572;
  localparam logic [15:0] WHITE_Y_RST = 16'd16384;
  localparam logic [15:0] WHITE_Z_RST = 16'd17839;

  typedef enum logic [1:0] {
    REG_WHITE_X = 2'b00,
    REG_WHITE_Y = 2'b01,
    REG_WHITE_Z = 2'b10
  } reg_index_t;

endpackage

/* src/linear_rgb_to_cielab.sv */
// Linear RGB to CIE L*a*b* converter, fully pipelined, one pixel per clock.
// Depends on lrc_pkg for the matrix, scaling constants and register indexes.
//
//   channel  | handshake                      | word
//   ---------+--------------------------------+------------------------------------
//   s_axis   | s_axis_tvalid / s_axis_tready  | red, green, blue (PIXEL_BITS each)
//   m_axis   | m_axis_tvalid / m_axis_tready  | lightness, a_star, b_star
//   cfg      | cfg_valid / cfg_ready (high)   | cfg_index, cfg_data
//
// From acceptance to a valid result a pixel passes the product, sum, divider,
// ratio, cube-root, f, scale and output registers; divider and root are one bit per stage.
// A new pixel is accepted every cycle; the whole pipeline advances together.
// When the output word is held by a low m_axis_tready, every stage holds.
// Reset (synchronous) clears all valid bits and loads the D65 white point.
module linear_rgb_to_cielab
  import lrc_pkg::*;
#(
  parameter int PIXEL_BITS = 12,
  localparam int IN_W = ((3 * PIXEL_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // red, green, blue, zero pad
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // lightness, a_star, b_star, zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam int P  = PIXEL_BITS;
  localparam int PW = P + 20;      // one matrix product
  localparam int SW = P + 21;      // one matrix row sum
  localparam int DW = P + 16;      // divisor maxv * white
  localparam int MW = 37;          // a* / b* product
  localparam int QW = 21;          // rounded a* / b* magnitude

  logic en;

  // Configuration registers and the divisors derived from them.
  logic [15:0] white [0:2];
  logic [DW-1:0] den [0:2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white[0] <= WHITE_X_RST;
      white[1] <= WHITE_Y_RST;
      white[2] <= WHITE_Z_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WHITE_X: white[0] <= cfg_data;
        REG_WHITE_Y: white[1] <= cfg_data;
        REG_WHITE_Z: white[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Divisor (2^P - 1) * white, as a shift and a subtract.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      den[c] <= (DW'(white[c]) << P) - DW'(white[c]);
    end
  end

  // The pipeline moves whenever the output word is free or being taken.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Matrix products.
  logic          b_vld;
  logic [PW-1:0] b_prod [0:2][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          b_prod[r][c] <= PW'(COEF[r][c]) * PW'(s_axis_tdata[c*P +: P]);
        end
      end
    end
  end

  // Row sums: X, Y and Z scaled by 2^20 * (2^P - 1).
  logic          c_vld;
  logic [SW-1:0] c_sum [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        c_sum[r] <= SW'(b_prod[r][0]) + SW'(b_prod[r][1]) + SW'(b_prod[r][2]);
      end
    end
  end

  // Long division of (sum << 18) by the divisor, one quotient bit per stage.
  // Stage 0 checks whether the quotient would reach 2^31 and loads the top bits.
  logic          dv_vld [0:TW];
  logic [DW-1:0] dv_rem [0:TW][0:2];
  logic [TW-1:0] dv_q   [0:TW][0:2];
  logic          dv_ovf [0:TW][0:2];
  logic [12:0]   dv_low [0:TW][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        dv_ovf[0][r] <= DW'(c_sum[r] >> 13) >= den[r];
        dv_rem[0][r] <= DW'(c_sum[r] >> 13);
        dv_q[0][r]   <= '0;
        dv_low[0][r] <= c_sum[r][12:0];
      end
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_div
    localparam int BI = TW - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    for (genvar r = 0; r < 3; r++) begin : g_ch
      logic        nbit;
      logic [DW:0] sh;
      logic [DW:0] diff;
      logic        ge;

      // The dividend's low 18 bits are zero.
      if (BI >= 18) begin : g_bit
        assign nbit = dv_low[k][r][BI-18];
      end else begin : g_zero
        assign nbit = 1'b0;
      end

      assign sh   = {dv_rem[k][r], nbit};
      assign diff = sh - {1'b0, den[r]};
      assign ge   = sh >= {1'b0, den[r]};

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1][r] <= ge ? diff[DW-1:0] : sh[DW-1:0];
          dv_q[k+1][r]   <= dv_q[k][r] | (TW'(ge) << BI);
          dv_ovf[k+1][r] <= dv_ovf[k][r];
          dv_low[k+1][r] <= dv_low[k][r];
        end
      end
    end
  end

  // Ratio, saturated to 64.0; a zero white register ends up here too.
  logic          t_vld;
  logic [TW-1:0] t_t [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (en) begin
      t_vld <= dv_vld[TW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        t_t[r] <= (dv_ovf[TW][r] || dv_q[TW][r] > T_MAX) ? T_MAX : dv_q[TW][r];
      end
    end
  end

  // Cube-root pipeline, one root bit per stage. Stage 0 also forms the
  // linear-segment products, which only matter below the threshold.
  logic            cr_vld   [0:RW];
  logic [RW-1:0]   cr_y     [0:RW][0:2];
  logic [2*RW-1:0] cr_y2    [0:RW][0:2];
  logic [CW-1:0]   cr_y3    [0:RW][0:2];
  logic [NW-1:0]   cr_n     [0:RW][0:2];
  logic [36:0]     cr_lin   [0:RW][0:2];
  logic            cr_above [0:RW][0:2];
  logic [34:0]     cr_low   [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_vld[0] <= 1'b0;
    end else if (en) begin
      cr_vld[0] <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cr_y[0][r]     <= '0;
        cr_y2[0][r]    <= '0;
        cr_y3[0][r]    <= '0;
        cr_n[0][r]     <= NW'(t_t[r]) << 24;
        cr_lin[0][r]   <= 37'(LIN_SLOPE) * 37'(t_t[r][17:0]);
        cr_above[0][r] <= t_t[r] > T_THRESH;
      end
      cr_low[0] <= 35'(L_SLOPE) * 35'(t_t[1][17:0]);
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_cbrt
    localparam int B = RW - 1 - j;

    always_ff @(posedge clk) begin
      if (rst) begin
        cr_vld[j+1] <= 1'b0;
      end else if (en) begin
        cr_vld[j+1] <= cr_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cr_low[j+1] <= cr_low[j];
      end
    end

    for (genvar r = 0; r < 3; r++) begin : g_ch
      logic [CW-1:0] c3;
      logic          take;

      // (y + 2^B)^3 = y^3 + 3 y^2 2^B + 3 y 2^2B + 2^3B
      assign c3 = cr_y3[j][r]
                + (CW'(cr_y2[j][r]) << (B + 1)) + (CW'(cr_y2[j][r]) << B)
                + (CW'(cr_y[j][r]) << (2 * B + 1)) + (CW'(cr_y[j][r]) << (2 * B))
                + (CW'(1) << (3 * B));
      assign take = c3 <= CW'(cr_n[j][r]);

      always_ff @(posedge clk) begin
        if (en) begin
          if (take) begin
            cr_y[j+1][r]  <= cr_y[j][r] | (RW'(1) << B);
            cr_y2[j+1][r] <= cr_y2[j][r] + ((2*RW)'(cr_y[j][r]) << (B + 1))
                           + ((2*RW)'(1) << (2 * B));
            cr_y3[j+1][r] <= c3;
          end else begin
            cr_y[j+1][r]  <= cr_y[j][r];
            cr_y2[j+1][r] <= cr_y2[j][r];
            cr_y3[j+1][r] <= cr_y3[j][r];
          end
          cr_n[j+1][r]     <= cr_n[j][r];
          cr_lin[j+1][r]   <= cr_lin[j][r];
          cr_above[j+1][r] <= cr_above[j][r];
        end
      end
    end
  end

  // f(t): cube root above the threshold, linear segment below it.
  logic          f_vld;
  logic [RW-1:0] f_f [0:2];
  logic [11:0]   f_lowl;
  logic          f_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= cr_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        f_f[r] <= cr_above[RW][r] ? cr_y[RW][r]
                : RW'((cr_lin[RW][r] + 37'(1 << 23)) >> 24) + RW'(LIN_OFFSET);
      end
      f_lowl  <= 12'((cr_low[RW] + 35'(1 << 23)) >> 24);
      f_above <= cr_above[RW][1];
    end
  end

  // Scale: L* upper branch, a* and b* differences.
  logic                 m_vld;
  logic [32:0]          m_pl;
  logic signed [MW-1:0] m_pab [0:1];
  logic [11:0]          m_lowl;
  logic                 m_above;
  logic signed [RW:0]   f_dif [0:1];

  always_comb begin
    f_dif[0] = $signed({1'b0, f_f[0]}) - $signed({1'b0, f_f[1]});
    f_dif[1] = $signed({1'b0, f_f[1]}) - $signed({1'b0, f_f[2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pl     <= 33'(L_SCALE) * 33'(f_f[1]);
      m_pab[0] <= MW'(A_SCALE) * MW'(f_dif[0]);
      m_pab[1] <= MW'(B_SCALE) * MW'(f_dif[1]);
      m_lowl   <= f_lowl;
      m_above  <= f_above;
    end
  end

  // Round, saturate and pack the output word.
  logic [17:0]     o_lu;
  logic [LW-1:0]   o_l;
  logic [ABW-1:0]  o_ab [0:1];
  logic            o_neg [0:1];
  logic [MW-1:0]   o_mag [0:1];
  logic [QW-1:0]   o_rnd [0:1];

  always_comb begin
    o_lu = 18'((m_pl + 33'd32768) >> 16);
    if (m_above) begin
      if (o_lu < L_OFS) begin
        o_l = '0;
      end else if (o_lu - L_OFS > 18'(L_MAX)) begin
        o_l = L_MAX;
      end else begin
        o_l = LW'(o_lu - L_OFS);
      end
    end else begin
      o_l = (14'(m_lowl) > L_MAX) ? L_MAX : 14'(m_lowl);
    end

    // Rounding is half away from zero, on the magnitude.
    for (int i = 0; i < 2; i++) begin
      o_neg[i] = m_pab[i][MW-1];
      o_mag[i] = o_neg[i] ? MW'(-m_pab[i]) : MW'(m_pab[i]);
      o_rnd[i] = QW'((o_mag[i] + MW'(32768)) >> 16);
      if (o_neg[i]) begin
        o_ab[i] = (o_rnd[i] > QW'(AB_NEG_MAX)) ? ABW'(-AB_NEG_MAX) : ABW'(-o_rnd[i]);
      end else begin
        o_ab[i] = (o_rnd[i] > QW'(AB_POS_MAX)) ? ABW'(AB_POS_MAX) : ABW'(o_rnd[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {(OUT_W - LW - 2 * ABW)'(0), o_ab[1], o_ab[0], o_l};
    end
  end

endmodule

/* src/lrc_check.sv */
// Port-level checker for linear_rgb_to_cielab, attached by the bind below.
// Depends on lrc_pkg for the result word layout and the lightness limit.
module lrc_check
  import lrc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A stalled output word stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed during a stall");

  // The input side is open exactly when the output word can move.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  // Lightness never exceeds 100.00.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[LW-1:0] <= L_MAX)
    else $error("lightness above limit");

  // a* and b* stay within their saturation limits.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $signed(m_axis_tdata[28:14]) >= -15'sd12800 &&
      $signed(m_axis_tdata[28:14]) <= 15'sd12799 &&
      $signed(m_axis_tdata[43:29]) >= -15'sd12800 &&
      $signed(m_axis_tdata[43:29]) <= 15'sd12799)
    else $error("a* or b* outside its limits");

  // No word is offered in the first cycle after reset is released.
  assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind linear_rgb_to_cielab lrc_check u_check (.*);
